>>> hdl/clc_pkg.sv
// ----------------------------------------------------------------------------
// clc_pkg
// Shared types and constants for the charge-limit controller.
// ----------------------------------------------------------------------------
package clc_pkg;

    localparam int LEVEL_W = 14;
    localparam int FULL_W  = 32;
    localparam int TIME_W  = 40;
    localparam int PCT_W   = 7;
    localparam int INDEX_W = 2;

    localparam logic [LEVEL_W-1:0] PCT_SCALE = LEVEL_W'(100);

    // threshold reset values, already scaled to hundredths of a percent
    localparam logic [LEVEL_W-1:0] THR_MIN_RST   = LEVEL_W'(40 * 100);
    localparam logic [LEVEL_W-1:0] THR_MAX_RST   = LEVEL_W'(100 * 100);
    localparam logic [LEVEL_W-1:0] THR_START_RST = LEVEL_W'(60 * 100);
    localparam logic [LEVEL_W-1:0] THR_END_RST   = LEVEL_W'(80 * 100);

    // register indexes of the configuration port
    localparam logic [INDEX_W-1:0] REG_THR_MIN   = 2'd0;
    localparam logic [INDEX_W-1:0] REG_THR_MAX   = 2'd1;
    localparam logic [INDEX_W-1:0] REG_THR_START = 2'd2;
    localparam logic [INDEX_W-1:0] REG_THR_END   = 2'd3;

    typedef enum logic [1:0] {
        CMD_LEVEL = 2'd0,
        CMD_FULL  = 2'd1,
        CMD_ALARM = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_SUSPEND = 2'd1,
        ACT_RESUME  = 2'd2
    } action_t;

    typedef struct packed {
        cmd_t                command;
        logic [LEVEL_W-1:0]  level;
        logic [FULL_W-1:0]   full_time;
        logic [TIME_W-1:0]   alarm_time;
        logic [TIME_W-1:0]   now_time;
    } item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] min_h;
        logic [LEVEL_W-1:0] max_h;
        logic [LEVEL_W-1:0] start_h;
        logic [LEVEL_W-1:0] end_h;
    } thr_t;

    typedef struct packed {
        logic    suspended;
        action_t action;
        logic    cycle;
    } result_t;

endpackage

>>> hdl/charge_limit_controller.sv
// ----------------------------------------------------------------------------
// charge_limit_controller
// Battery charge-limit controller with hysteresis on level and alarm time.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one event word per valid/ready handshake: a level update,
//   a time-to-full update or an alarm update, each with the current time.
//   m_* returns exactly one result word per event: the suspended flag,
//   the action taken and the cycle flag after the event.
//   cfg_we/cfg_index/cfg_wdata write the four percent thresholds; write them
//   only while no event is in flight.
// Pipeline and throughput:
//   an accepted event is decided from the input register into the result
//   register that drives m_*. The decision is one pass of compares and a
//   40-bit subtract, so one event is taken every cycle unless m_* stalls.
// Reset:
//   aresetn low clears both flags and the stored level, alarm and
//   time-to-full, loads thresholds 40/100/60/80 and empties the pipeline.
// Stall:
//   a held result stays on m_*; one more event is still taken into the input
//   register, after which s_ready drops until m_ready frees the result.
// ----------------------------------------------------------------------------
module charge_limit_controller
    import clc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_we,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [PCT_W-1:0]   cfg_wdata,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [LEVEL_W-1:0] s_level_hundredths,
    input  logic [FULL_W-1:0]  s_full_time_s,
    input  logic [TIME_W-1:0]  s_alarm_time,
    input  logic [TIME_W-1:0]  s_now_time,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_charging_suspended,
    output logic [1:0]         m_action,
    output logic               m_cycle_active
);

    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;
    thr_t    thr;
    logic    advance;
    logic    s_fire;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    clc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .thr       (thr)
    );

    clc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .thr     (thr),
        .result  (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg.command    <= cmd_t'(s_command);
            item_reg.level      <= s_level_hundredths;
            item_reg.full_time  <= s_full_time_s;
            item_reg.alarm_time <= s_alarm_time;
            item_reg.now_time   <= s_now_time;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_charging_suspended = result_reg.suspended;
    assign m_action             = result_reg.action;
    assign m_cycle_active       = result_reg.cycle;

    // a suspend word always reports charging suspended
    a_suspend_flag : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_action == ACT_SUSPEND) |-> m_charging_suspended)
        else $error("suspend word without suspended flag");

    // a resume word always reports charging enabled
    a_resume_flag : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_action == ACT_RESUME) |-> !m_charging_suspended)
        else $error("resume word with suspended flag");

    // an empty result stage never blocks the input side
    a_ready_when_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with empty result stage");

    // a stalled result word is only replaced once taken
    a_hold_stalled : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(result_reg)))
        else $error("result word changed while stalled");

endmodule

>>> hdl/clc_cfg.sv
// ----------------------------------------------------------------------------
// clc_cfg
// Threshold registers; percent values are scaled to hundredths on write.
// ----------------------------------------------------------------------------
module clc_cfg
    import clc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [PCT_W-1:0]   cfg_wdata,
    output thr_t               thr
);

    thr_t               thr_reg;
    logic [LEVEL_W-1:0] scaled;

    // constant multiply, at most 127 * 100
    assign scaled = LEVEL_W'(cfg_wdata) * PCT_SCALE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg.min_h   <= THR_MIN_RST;
            thr_reg.max_h   <= THR_MAX_RST;
            thr_reg.start_h <= THR_START_RST;
            thr_reg.end_h   <= THR_END_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_THR_MIN:   thr_reg.min_h   <= scaled;
                REG_THR_MAX:   thr_reg.max_h   <= scaled;
                REG_THR_START: thr_reg.start_h <= scaled;
                REG_THR_END:   thr_reg.end_h   <= scaled;
                default: ;
            endcase
        end
    end

    assign thr = thr_reg;

endmodule

>>> hdl/clc_core.sv
// ----------------------------------------------------------------------------
// clc_core
// Controller state and the suspend / resume decision for one event.
// ----------------------------------------------------------------------------
module clc_core
    import clc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  item_t   item,
    input  thr_t    thr,
    output result_t result
);

    logic               suspended_reg, suspended_next;
    logic               cycle_reg, cycle_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [TIME_W-1:0]  alarm_reg, alarm_next;
    logic [FULL_W-1:0]  full_reg, full_next;

    logic [LEVEL_W-1:0] level_eff;
    logic [TIME_W-1:0]  alarm_eff;
    logic [FULL_W-1:0]  full_eff;
    logic               run;
    logic [TIME_W-1:0]  time_left;
    logic               alarm_near;
    action_t            action;

    // event updates the stored value before the decision looks at it
    always_comb begin
        level_eff = level_reg;
        alarm_eff = alarm_reg;
        full_eff  = full_reg;
        run       = 1'b0;
        case (item.command)
            CMD_LEVEL: begin
                level_eff = item.level;
                run       = 1'b1;
            end
            CMD_FULL: begin
                if (!suspended_reg) begin
                    full_eff = item.full_time;
                    run      = 1'b1;
                end
            end
            CMD_ALARM: begin
                alarm_eff = item.alarm_time;
                run       = 1'b1;
            end
            default: ;
        endcase
    end

    // unsigned time left, a past alarm never counts as near
    assign time_left  = alarm_eff - item.now_time;
    assign alarm_near = (alarm_eff >= item.now_time) &&
                        (time_left < TIME_W'(full_eff));

    always_comb begin
        suspended_next = suspended_reg;
        cycle_next     = cycle_reg;
        level_next     = level_eff;
        alarm_next     = alarm_eff;
        full_next      = full_eff;
        action         = ACT_NONE;
        if (run) begin
            if (suspended_reg) begin
                if (alarm_eff != '0 && full_eff != '0) begin
                    if (alarm_near) begin
                        suspended_next = 1'b0;
                        alarm_next     = item.alarm_time;
                        action         = ACT_RESUME;
                    end
                end else if (alarm_eff == '0 && !cycle_reg &&
                             level_eff <= thr.start_h) begin
                    suspended_next = 1'b0;
                    action         = ACT_RESUME;
                end else if (level_eff < thr.min_h) begin
                    cycle_next     = 1'b0;
                    suspended_next = 1'b0;
                    action         = ACT_RESUME;
                end
            end else begin
                if (!cycle_reg && level_eff >= thr.end_h) begin
                    cycle_next     = 1'b1;
                    suspended_next = 1'b1;
                    action         = ACT_SUSPEND;
                end else if (level_eff == thr.max_h) begin
                    suspended_next = 1'b1;
                    action         = ACT_SUSPEND;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            suspended_reg <= 1'b0;
            cycle_reg     <= 1'b0;
            level_reg     <= '0;
            alarm_reg     <= '0;
            full_reg      <= '0;
        end else if (advance) begin
            suspended_reg <= suspended_next;
            cycle_reg     <= cycle_next;
            level_reg     <= level_next;
            alarm_reg     <= alarm_next;
            full_reg      <= full_next;
        end
    end

    assign result.suspended = suspended_next;
    assign result.action    = action;
    assign result.cycle     = cycle_next;

endmodule

>>> verif/charge_limit_controller_test.sv
// ----------------------------------------------------------------------------
// charge_limit_controller_test
// Self-checking bench for the charge-limit controller. A short directed table
// walks the suspend/resume paths under the reset thresholds, then randomized
// level, time-to-full and alarm events run under several threshold settings.
// Every result word is checked field by field against a table row's value or
// an in-bench predictor, with event-side gaps and result-side stalls at random.
// ----------------------------------------------------------------------------
module charge_limit_controller_test;
    import clc_pkg::*;

    localparam logic [1:0]  CMD_SPARE   = 2'd3;    // not decoded by the block
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int          PHASES      = 9;
    localparam int          PHASE_ITEMS = 148;

    typedef struct packed {
        logic [1:0]         command;
        logic [LEVEL_W-1:0] level;
        logic [FULL_W-1:0]  full;
        logic [TIME_W-1:0]  alarm;
        logic [TIME_W-1:0]  now;
    } event_word_t;

    typedef struct packed {
        event_word_t w;
        logic        known;
        result_t     want;
    } plan_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [INDEX_W-1:0] cfg_index = '0;
    logic [PCT_W-1:0]   cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_command = '0;
    logic [LEVEL_W-1:0] s_level_hundredths = '0;
    logic [FULL_W-1:0]  s_full_time_s = '0;
    logic [TIME_W-1:0]  s_alarm_time = '0;
    logic [TIME_W-1:0]  s_now_time = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_charging_suspended;
    logic [1:0]         m_action;
    logic               m_cycle_active;

    charge_limit_controller dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_command            (s_command),
        .s_level_hundredths   (s_level_hundredths),
        .s_full_time_s        (s_full_time_s),
        .s_alarm_time         (s_alarm_time),
        .s_now_time           (s_now_time),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_charging_suspended (m_charging_suspended),
        .m_action             (m_action),
        .m_cycle_active       (m_cycle_active)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // predictor copy of thresholds and controller state
    logic [PCT_W-1:0]   pct_min = 7'd40;
    logic [PCT_W-1:0]   pct_max = 7'd100;
    logic [PCT_W-1:0]   pct_start = 7'd60;
    logic [PCT_W-1:0]   pct_end = 7'd80;
    logic               parked = 1'b0;
    logic               in_cycle = 1'b0;
    logic [LEVEL_W-1:0] last_level = '0;
    logic [TIME_W-1:0]  alarm_at = '0;
    logic [FULL_W-1:0]  secs_to_full = '0;

    result_t     expected_q[$];
    plan_row_t   plan[$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int          tx_run = 0;
    bit          tx_lazy = 1'b0;
    int          rx_run = 0;
    bit          rx_lazy = 1'b0;
    logic [TIME_W-1:0]  clock_now = '0;
    logic [LEVEL_W-1:0] drift_level = '0;

    function automatic logic [15:0] to_hundredths(input logic [PCT_W-1:0] pct);
        return 16'(pct) * 16'd100;
    endfunction

    function automatic action_t settle_charging(input logic [TIME_W-1:0] alarm_in,
                                                input logic [TIME_W-1:0] now);
        if (parked) begin
            if (alarm_at != '0 && secs_to_full != '0) begin
                // unsigned time left: a past alarm never resumes
                if (alarm_at >= now && (alarm_at - now) < {8'd0, secs_to_full}) begin
                    parked = 1'b0;
                    alarm_at = alarm_in;
                    return ACT_RESUME;
                end
            end else if (alarm_at == '0 && !in_cycle &&
                         {2'b00, last_level} <= to_hundredths(pct_start)) begin
                parked = 1'b0;
                return ACT_RESUME;
            end else if ({2'b00, last_level} < to_hundredths(pct_min)) begin
                in_cycle = 1'b0;
                parked = 1'b0;
                return ACT_RESUME;
            end
        end else begin
            if (!in_cycle && {2'b00, last_level} >= to_hundredths(pct_end)) begin
                in_cycle = 1'b1;
                parked = 1'b1;
                return ACT_SUSPEND;
            end else if ({2'b00, last_level} == to_hundredths(pct_max)) begin
                parked = 1'b1;
                return ACT_SUSPEND;
            end
        end
        return ACT_NONE;
    endfunction

    function automatic result_t predict_event(input event_word_t w);
        action_t act;
        act = ACT_NONE;
        case (w.command)
            CMD_LEVEL: begin
                last_level = w.level;
                act = settle_charging(w.alarm, w.now);
            end
            CMD_FULL: begin
                // time-to-full is dropped while suspended
                if (!parked) begin
                    secs_to_full = w.full;
                    act = settle_charging(w.alarm, w.now);
                end
            end
            CMD_ALARM: begin
                alarm_at = w.alarm;
                act = settle_charging(w.alarm, w.now);
            end
            default: ;
        endcase
        return result_t'{parked, act, in_cycle};
    endfunction

    function automatic int draw_wait(inout int run_left, inout bit lazy);
        if (run_left == 0) begin
            run_left = int'($urandom_range(8, 60));
            lazy = ($urandom_range(0, 3) != 0);
        end
        run_left--;
        return lazy ? int'($urandom_range(0, 13)) : 0;
    endfunction

    function automatic logic [TIME_W-1:0] rand40();
        return {8'($urandom), 32'($urandom)};
    endfunction

    function automatic void add_row(input logic [1:0] cmd, input logic [LEVEL_W-1:0] lvl,
                                    input logic [FULL_W-1:0] full,
                                    input logic [TIME_W-1:0] alarm,
                                    input logic [TIME_W-1:0] now, input logic known,
                                    input logic sus, input action_t act, input logic cyc);
        plan_row_t r;
        r.w = event_word_t'{cmd, lvl, full, alarm, now};
        r.known = known;
        r.want = result_t'{sus, act, cyc};
        plan.push_back(r);
    endfunction

    function automatic logic [LEVEL_W-1:0] random_level();
        int v;
        int unsigned r;
        logic [PCT_W-1:0] p;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            // slow drift, like a real battery
            v = int'(drift_level) + int'($urandom_range(0, 300)) - 150;
            if (v < 0) v = 0;
            if (v > 10000) v = 10000;
            drift_level = LEVEL_W'(v);
            return drift_level;
        end else if (r < 65) begin
            case ($urandom_range(0, 3))
                0: p = pct_min;
                1: p = pct_max;
                2: p = pct_start;
                default: p = pct_end;
            endcase
            v = int'(to_hundredths(p)) + int'($urandom_range(0, 6)) - 3;
            if (v < 0) v = 0;
            if (v > 16383) v = 16383;
            return LEVEL_W'(v);
        end else if (r < 75) begin
            return ($urandom_range(0, 1) != 0) ? LEVEL_W'(10000) : LEVEL_W'(0);
        end else if (r < 85) begin
            return LEVEL_W'($urandom);
        end
        return LEVEL_W'($urandom_range(0, 10000));
    endfunction

    function automatic event_word_t random_word();
        event_word_t w;
        int unsigned r;
        if ($urandom_range(0, 99) < 3) clock_now = rand40();
        else clock_now = clock_now + TIME_W'($urandom_range(0, 600));
        r = $urandom_range(0, 99);
        if (r < 50) w.command = CMD_LEVEL;
        else if (r < 70) w.command = CMD_FULL;
        else if (r < 94) w.command = CMD_ALARM;
        else w.command = CMD_SPARE;
        w.level = random_level();
        r = $urandom_range(0, 99);
        if (r < 15) w.full = '0;
        else if (r < 65) w.full = FULL_W'($urandom_range(1, 20000));
        else w.full = FULL_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 20) w.alarm = '0;
        else if (r < 60) w.alarm = clock_now + TIME_W'($urandom_range(0, 25000));
        else if (r < 70) w.alarm = clock_now;
        else if (r < 85) w.alarm = clock_now - TIME_W'($urandom_range(1, 5000));
        else w.alarm = rand40();
        w.now = clock_now;
        return w;
    endfunction

    function automatic logic [PCT_W-1:0] random_pct();
        if ($urandom_range(0, 9) == 0) return PCT_W'($urandom_range(101, 127));
        return PCT_W'($urandom_range(0, 100));
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("result %0d: %s got %0h want %0h", results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic send_word(input event_word_t w, input logic known, input result_t typed);
        int gap;
        result_t pred;
        gap = draw_wait(tx_run, tx_lazy);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_command          <= w.command;
        s_level_hundredths <= w.level;
        s_full_time_s      <= w.full;
        s_alarm_time       <= w.alarm;
        s_now_time         <= w.now;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pred = predict_event(w);
        expected_q.push_back(known ? typed : pred);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [PCT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_THR_MIN:   pct_min = val;
            REG_THR_MAX:   pct_max = val;
            REG_THR_START: pct_start = val;
            REG_THR_END:   pct_end = val;
            default: ;
        endcase
    endtask

    task automatic load_thresholds(input logic [PCT_W-1:0] lo, input logic [PCT_W-1:0] hi,
                                   input logic [PCT_W-1:0] st, input logic [PCT_W-1:0] en);
        write_reg(REG_THR_MIN, lo);
        write_reg(REG_THR_MAX, hi);
        write_reg(REG_THR_START, st);
        write_reg(REG_THR_END, en);
        cfg_we <= 1'b0;
    endtask

    // result side: random stalls, compare against the oldest expectation
    initial begin
        int stall;
        result_t want;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_wait(rx_run, rx_lazy);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (expected_q.size() == 0) begin
                note_mismatch("unexpected word, action", 64'(m_action), 64'(0));
            end else begin
                want = expected_q.pop_front();
                if (m_charging_suspended !== want.suspended)
                    note_mismatch("charging_suspended", 64'(m_charging_suspended),
                                  64'(want.suspended));
                if (m_action !== want.action)
                    note_mismatch("action", 64'(m_action), 64'(want.action));
                if (m_cycle_active !== want.cycle)
                    note_mismatch("cycle_active", 64'(m_cycle_active), 64'(want.cycle));
            end
            results_seen++;
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("charge_limit_controller: mismatch");
        $finish;
    end

    initial begin
        // directed: reset thresholds 40/100/60/80
        add_row(CMD_SPARE, 0, 0, 0, 0, 1, 0, ACT_NONE, 0);
        add_row(CMD_LEVEL, 0, 0, 0, 10, 1, 0, ACT_NONE, 0);
        add_row(CMD_LEVEL, 10000, 0, 0, 20, 1, 1, ACT_SUSPEND, 1);
        // time-to-full dropped while suspended
        add_row(CMD_FULL, 0, 5000, 0, 30, 1, 1, ACT_NONE, 1);
        add_row(CMD_LEVEL, 7000, 0, 0, 40, 0, 0, ACT_NONE, 0);
        add_row(CMD_LEVEL, 3999, 0, 0, 50, 1, 0, ACT_RESUME, 0);
        add_row(CMD_FULL, 0, 32'hFFFF_FFFF, 0, 60, 0, 0, ACT_NONE, 0);
        add_row(CMD_LEVEL, 8000, 0, 0, 70, 1, 1, ACT_SUSPEND, 1);
        add_row(CMD_ALARM, 0, 0, 40'd1000100, 40'd1000000, 0, 0, ACT_NONE, 0);
        add_row(CMD_LEVEL, 10000, 0, 40'd1000100, 40'd1000050, 0, 0, ACT_NONE, 0);
        // alarm already past
        add_row(CMD_ALARM, 0, 0, 500, 1000, 1, 1, ACT_NONE, 1);
        // alarm exactly now, zero time left
        add_row(CMD_ALARM, 0, 0, 2000, 2000, 1, 0, ACT_RESUME, 1);
        add_row(CMD_LEVEL, 14'h3FFF, 0, 2000, 2100, 0, 0, ACT_NONE, 0);
        add_row(CMD_LEVEL, 10000, 0, 2000, 2200, 0, 0, ACT_NONE, 0);
        add_row(CMD_ALARM, 0, 0, 40'hFF_FFFF_FFFF, 0, 1, 1, ACT_NONE, 1);
        // resume reloads the alarm from this word's field
        add_row(CMD_LEVEL, 9000, 0, 0, 40'hFF_FFFF_FFFF, 0, 0, ACT_NONE, 0);
        add_row(CMD_ALARM, 0, 0, 0, 5, 0, 0, ACT_NONE, 0);
        add_row(CMD_LEVEL, 10000, 0, 0, 6, 0, 0, ACT_NONE, 0);
        add_row(CMD_LEVEL, 5000, 0, 0, 7, 0, 0, ACT_NONE, 0);
        add_row(CMD_LEVEL, 100, 0, 0, 8, 0, 0, ACT_NONE, 0);
        add_row(CMD_FULL, 0, 0, 0, 9, 0, 0, ACT_NONE, 0);
        add_row(CMD_LEVEL, 10000, 0, 0, 10, 1, 1, ACT_SUSPEND, 1);
        add_row(CMD_ALARM, 0, 0, 3000, 1000, 0, 0, ACT_NONE, 0);
        add_row(CMD_SPARE, 14'h3FFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF,
                1, 1, ACT_NONE, 1);
        add_row(CMD_LEVEL, 0, 0, 0, 11, 0, 0, ACT_NONE, 0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) send_word(plan[i].w, plan[i].known, plan[i].want);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            case (phase)
                0: load_thresholds(7'd40, 7'd100, 7'd60, 7'd80);
                1: load_thresholds(7'd0, 7'd0, 7'd0, 7'd0);
                2: load_thresholds(7'd100, 7'd100, 7'd100, 7'd100);
                3: load_thresholds(7'd127, 7'd127, 7'd127, 7'd127);
                // max below end, so a suspend can happen outside a cycle
                4: load_thresholds(7'd10, 7'd50, 7'd30, 7'd90);
                default: load_thresholds(random_pct(), random_pct(), random_pct(),
                                         random_pct());
            endcase
            clock_now = rand40();
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_word(random_word(), 1'b0, result_t'(0));
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("charge_limit_controller: match");
        end else begin
            $display("charge_limit_controller: mismatch");
        end
        $finish;
    end

endmodule
